### src/sm83_low_opcode_execute_defines.svh
// Assertion macros shared by the execute block's modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef SM83_LOW_OPCODE_EXECUTE_DEFINES_SVH
`define SM83_LOW_OPCODE_EXECUTE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SM83_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SM83_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SM83_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SM83_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/sm83_pkg.sv
// Shared types and constants for the SM83 low-page execute block.
// No dependencies.
`default_nettype none
package sm83_pkg;
    localparam logic [15:0] SP_RESET = 16'hFFFE;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_NOP, OP_LD16, OP_ST8, OP_INC16, OP_DEC16, OP_INC8, OP_DEC8, OP_LD8,
        OP_ROT, OP_STSP, OP_ADDHL, OP_LDA, OP_JR, OP_UNSUP
    } op_class_t;

    // Decoded request handed from the front end to the back end.
    typedef struct packed {
        op_class_t  cls;
        logic       use_de;
        logic       high_byte;
        logic [1:0] rot_kind;   // 0 RLCA, 1 RRCA, 2 RLA, 3 RRA
        logic [4:0] cycles;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] mem_data;
    } dec_req_t;
endpackage
`default_nettype wire

### src/sm83_decode.sv
// Front end: classifies an opcode into a decoded request.
// Depends on sm83_pkg.
`default_nettype none
module sm83_decode (
    input  wire logic [7:0]      opcode,
    input  wire logic [7:0]      imm_low,
    input  wire logic [7:0]      imm_high,
    input  wire logic [7:0]      mem_data,
    output sm83_pkg::dec_req_t   req
);
    always_comb begin
        req = '0;
        req.use_de = opcode[4];
        req.high_byte = ~opcode[3];
        req.rot_kind = {opcode[4], opcode[3]};
        req.imm_low = imm_low;
        req.imm_high = imm_high;
        req.mem_data = mem_data;
        req.cls = sm83_pkg::OP_UNSUP;
        req.cycles = 5'd0;
        if (opcode[7:5] == 3'b000 && opcode != 8'h10) begin
            case (opcode[2:0])
                3'd0: begin
                    case (opcode[4:3])
                        2'd0: begin req.cls = sm83_pkg::OP_NOP; req.cycles = 5'd4; end
                        2'd1: begin req.cls = sm83_pkg::OP_STSP; req.cycles = 5'd20; end
                        default: begin req.cls = sm83_pkg::OP_JR; req.cycles = 5'd12; end
                    endcase
                end
                3'd1: begin
                    req.cls = opcode[3] ? sm83_pkg::OP_ADDHL : sm83_pkg::OP_LD16;
                    req.cycles = opcode[3] ? 5'd8 : 5'd12;
                end
                3'd2: begin
                    req.cls = opcode[3] ? sm83_pkg::OP_LDA : sm83_pkg::OP_ST8;
                    req.cycles = 5'd8;
                end
                3'd3: begin
                    req.cls = opcode[3] ? sm83_pkg::OP_DEC16 : sm83_pkg::OP_INC16;
                    req.cycles = 5'd8;
                end
                3'd4: begin req.cls = sm83_pkg::OP_INC8; req.cycles = 5'd4; end
                3'd5: begin req.cls = sm83_pkg::OP_DEC8; req.cycles = 5'd4; end
                3'd6: begin req.cls = sm83_pkg::OP_LD8; req.cycles = 5'd8; end
                default: begin req.cls = sm83_pkg::OP_ROT; req.cycles = 5'd4; end
            endcase
        end
    end
endmodule
`default_nettype wire

### src/sm83_queue.sv
// Two-entry request queue between the decoder and the execute stage.
// Depends on sm83_pkg.
`default_nettype none
module sm83_queue #(
    parameter int DEPTH = sm83_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sm83_pkg::dec_req_t in_req,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sm83_pkg::dec_req_t      out_req
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    sm83_pkg::dec_req_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_req   = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push) wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (pop)  rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= in_req;
    end

    `include "sm83_low_opcode_execute_defines.svh"
    `SM83_ASSERT_IMPL(a_no_overflow, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `SM83_ASSERT_NEXT(a_push_only, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + (AW+1)'(1))
    `SM83_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !push, cnt_reg == $past(cnt_reg) - (AW+1)'(1))
endmodule
`default_nettype wire

### src/sm83_execute.sv
// Back end: holds the architectural registers and executes decoded requests
// into a registered result. Depends on sm83_pkg.
`default_nettype none
module sm83_execute (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire sm83_pkg::dec_req_t req,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [119:0]            res_data
);
    logic [15:0] sp_reg;
    logic [7:0]  a_reg, a_next;
    logic [3:0]  f_reg, f_next;
    logic [15:0] bc_reg, bc_next, de_reg, de_next, hl_reg, hl_next, pc_reg, pc_next;
    logic        res_valid_reg;
    logic [119:0] res_reg, res_next;
    logic [15:0] pair, pair_new, n16, len, wa, wd;
    logic [7:0]  r8, r8_new;
    logic [16:0] sum;
    logic [12:0] hsum;
    logic        we, two, unsup, fire;

    assign req_ready = !res_valid_reg || res_ready;
    assign fire = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res_data = res_reg;

    always_comb begin
        n16 = {req.imm_high, req.imm_low};
        pair = req.use_de ? de_reg : bc_reg;
        r8 = req.high_byte ? pair[15:8] : pair[7:0];
        a_next = a_reg; f_next = f_reg; bc_next = bc_reg; de_next = de_reg;
        hl_next = hl_reg; pair_new = pair; len = 16'd1;
        we = 1'b0; two = 1'b0; wa = '0; wd = '0; unsup = 1'b0;
        r8_new = r8;
        sum = {1'b0, hl_reg} + {1'b0, pair};
        hsum = {1'b0, hl_reg[11:0]} + {1'b0, pair[11:0]};
        case (req.cls)
            sm83_pkg::OP_NOP: ;
            sm83_pkg::OP_LD16: begin pair_new = n16; len = 16'd3; end
            sm83_pkg::OP_ST8: begin we = 1'b1; wa = pair; wd = {8'd0, a_reg}; end
            sm83_pkg::OP_INC16: pair_new = pair + 16'd1;
            sm83_pkg::OP_DEC16: pair_new = pair - 16'd1;
            sm83_pkg::OP_INC8: begin
                r8_new = r8 + 8'd1;
                f_next = {r8_new == 8'd0, 1'b0, r8[3:0] == 4'hF, f_reg[0]};
            end
            sm83_pkg::OP_DEC8: begin
                r8_new = r8 - 8'd1;
                f_next = {r8_new == 8'd0, 1'b1, r8[3:0] == 4'h0, f_reg[0]};
            end
            sm83_pkg::OP_LD8: begin r8_new = req.imm_low; len = 16'd2; end
            sm83_pkg::OP_ROT: begin
                case (req.rot_kind)
                    2'd0: begin a_next = {a_reg[6:0], a_reg[7]}; f_next = {3'b0, a_reg[7]}; end
                    2'd1: begin a_next = {a_reg[0], a_reg[7:1]}; f_next = {3'b0, a_reg[0]}; end
                    2'd2: begin a_next = {a_reg[6:0], f_reg[0]}; f_next = {3'b0, a_reg[7]}; end
                    default: begin
                        a_next = {f_reg[0], a_reg[7:1]}; f_next = {3'b0, a_reg[0]};
                    end
                endcase
            end
            sm83_pkg::OP_STSP: begin
                we = 1'b1; two = 1'b1; wa = n16; wd = sp_reg; len = 16'd3;
            end
            sm83_pkg::OP_ADDHL: begin
                hl_next = sum[15:0];
                f_next = {f_reg[3], 1'b0, hsum[12], sum[16]};
            end
            sm83_pkg::OP_LDA: a_next = req.mem_data;
            sm83_pkg::OP_JR: len = 16'd2 + {{8{req.imm_low[7]}}, req.imm_low};
            default: begin unsup = 1'b1; len = 16'd0; end
        endcase
        if (req.cls == sm83_pkg::OP_INC8 || req.cls == sm83_pkg::OP_DEC8
            || req.cls == sm83_pkg::OP_LD8)
            pair_new = req.high_byte ? {r8_new, pair[7:0]} : {pair[15:8], r8_new};
        if (req.use_de) de_next = pair_new;
        else bc_next = pair_new;
        pc_next = pc_reg + len;
        res_next = {unsup, wd, wa, two, we, req.cycles, pc_next, hl_next, de_next,
                    bc_next, f_next, 4'b0, a_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= sm83_pkg::SP_RESET;
            a_reg <= '0; f_reg <= '0; bc_reg <= '0; de_reg <= '0;
            hl_reg <= '0; pc_reg <= '0; res_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) sp_reg <= cfg_wdata;
            if (fire) begin
                a_reg <= a_next; f_reg <= f_next; bc_reg <= bc_next;
                de_reg <= de_next; hl_reg <= hl_next; pc_reg <= pc_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res_next;
    end

    `include "sm83_low_opcode_execute_defines.svh"
    `SM83_ASSERT_NEXT(a_stall_hold, aclk, aresetn, res_valid_reg && !res_ready, res_valid_reg)
    `SM83_ASSERT_NEXT(a_unsup_keeps_pc, aclk, aresetn, fire && req.cls == sm83_pkg::OP_UNSUP, pc_reg == $past(pc_reg))
    `SM83_ASSERT_IMPL(a_flag_low, aclk, aresetn, res_valid_reg, res_reg[11:8] == 4'b0)
endmodule
`default_nettype wire

### src/sm83_low_opcode_execute.sv
// SM83 low-page execute block: one opcode 0x00..0x1F per request.
// A request reaches the result through the queue entry and then the execute register.
// Throughput: one request per cycle while the result side is ready; the execute stage's register update loop sets it.
// A two-entry queue decouples decode from execute so either side can stall.
// Reset (aresetn low, synchronous) clears the CPU registers and queue; stack pointer returns to 0xFFFE.
`default_nettype none
module sm83_low_opcode_execute #(
    parameter int QUEUE_DEPTH = sm83_pkg::QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode[7:0], imm_low[15:8], imm_high[23:16], mem_data[31:24]
    input  wire logic [31:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // acc_out, flags_out, bc_out, de_out, hl_out, pc_out, cycles_taken,
    // write_enable, write_two_bytes, write_address, write_data, unsupported
    output logic [119:0]      m_tdata
);
    sm83_pkg::dec_req_t dreq, qreq;
    logic q_valid, q_ready;

    sm83_decode u_dec (
        .opcode(s_tdata[7:0]), .imm_low(s_tdata[15:8]),
        .imm_high(s_tdata[23:16]), .mem_data(s_tdata[31:24]), .req(dreq)
    );

    sm83_queue #(.DEPTH(QUEUE_DEPTH)) u_q (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_req(dreq),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(qreq)
    );

    sm83_execute u_ex (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .req_valid(q_valid), .req_ready(q_ready),
        .req(qreq), .res_valid(m_tvalid), .res_ready(m_tready), .res_data(m_tdata)
    );
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for sm83_low_opcode_execute: directed and random
// instruction streams checked against an in-bench model of the SM83 low page.
// Depends on sm83_pkg and the sm83_low_opcode_execute RTL.
`default_nettype none
module tb;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] OPC_NOP     = 8'h00;
    localparam logic [7:0] OPC_LD_BC   = 8'h01;
    localparam logic [7:0] OPC_ST_BC   = 8'h02;
    localparam logic [7:0] OPC_INC_B   = 8'h04;
    localparam logic [7:0] OPC_DEC_B   = 8'h05;
    localparam logic [7:0] OPC_LD_B    = 8'h06;
    localparam logic [7:0] OPC_RLCA    = 8'h07;
    localparam logic [7:0] OPC_ST_SP   = 8'h08;
    localparam logic [7:0] OPC_ADD_BC  = 8'h09;
    localparam logic [7:0] OPC_LDA_BC  = 8'h0A;
    localparam logic [7:0] OPC_DEC_BC  = 8'h0B;
    localparam logic [7:0] OPC_INC_C   = 8'h0C;
    localparam logic [7:0] OPC_DEC_C   = 8'h0D;
    localparam logic [7:0] OPC_LD_C    = 8'h0E;
    localparam logic [7:0] OPC_RRCA    = 8'h0F;
    localparam logic [7:0] OPC_STOP    = 8'h10;
    localparam logic [7:0] OPC_LD_DE   = 8'h11;
    localparam logic [7:0] OPC_ST_DE   = 8'h12;
    localparam logic [7:0] OPC_INC_DE  = 8'h13;
    localparam logic [7:0] OPC_INC_D   = 8'h14;
    localparam logic [7:0] OPC_DEC_D   = 8'h15;
    localparam logic [7:0] OPC_LD_D    = 8'h16;
    localparam logic [7:0] OPC_RLA     = 8'h17;
    localparam logic [7:0] OPC_JR      = 8'h18;
    localparam logic [7:0] OPC_ADD_DE  = 8'h19;
    localparam logic [7:0] OPC_LDA_DE  = 8'h1A;
    localparam logic [7:0] OPC_DEC_DE  = 8'h1B;
    localparam logic [7:0] OPC_INC_E   = 8'h1C;
    localparam logic [7:0] OPC_DEC_E   = 8'h1D;
    localparam logic [7:0] OPC_LD_E    = 8'h1E;
    localparam logic [7:0] OPC_RRA     = 8'h1F;
    localparam logic [7:0] OPC_INC_BC  = 8'h03;

    localparam logic [3:0] FLAG_Z = 4'h8;
    localparam logic [3:0] FLAG_N = 4'h4;
    localparam logic [3:0] FLAG_H = 4'h2;
    localparam logic [3:0] FLAG_C = 4'h1;

    typedef struct packed {
        logic [7:0] mem_data;
        logic [7:0] imm_high;
        logic [7:0] imm_low;
        logic [7:0] opcode;
    } instr_t;

    typedef struct packed {
        logic        unsupported;
        logic [15:0] write_data;
        logic [15:0] write_address;
        logic        write_two_bytes;
        logic        write_enable;
        logic [4:0]  cycles_taken;
        logic [15:0] pc_out;
        logic [15:0] hl_out;
        logic [15:0] de_out;
        logic [15:0] bc_out;
        logic [7:0]  flags_out;
        logic [7:0]  acc_out;
    } cpu_state_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;

    sm83_low_opcode_execute DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Model state
    logic [15:0] sp_model;
    logic [7:0]  a_reg;
    logic [3:0]  f_reg;
    logic [15:0] bc_reg, de_reg, hl_reg, pc_reg;

    instr_t     pending_instrs[$];
    cpu_state_t expected_states[$];
    int         mismatches;
    int         results_seen;
    int         idle_cycles;
    int         gap_left, burst_left;
    int         stall_phase;
    bit         hold_sender;
    bit         in_taken;
    int         unsup_seen, writes_seen;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] incr8(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'd1;
        f_reg = (f_reg & FLAG_C) | (r == 8'd0 ? FLAG_Z : 4'h0) |
                (v[3:0] == 4'hF ? FLAG_H : 4'h0);
        return r;
    endfunction

    function automatic logic [7:0] decr8(input logic [7:0] v);
        logic [7:0] r;
        r = v - 8'd1;
        f_reg = (f_reg & FLAG_C) | FLAG_N | (r == 8'd0 ? FLAG_Z : 4'h0) |
                (v[3:0] == 4'h0 ? FLAG_H : 4'h0);
        return r;
    endfunction

    function automatic logic [15:0] add_to_hl(input logic [15:0] rr);
        logic [16:0] sum;
        logic [12:0] half;
        sum = {1'b0, hl_reg} + {1'b0, rr};
        half = {1'b0, hl_reg[11:0]} + {1'b0, rr[11:0]};
        f_reg = (f_reg & FLAG_Z) | (half[12] ? FLAG_H : 4'h0) | (sum[16] ? FLAG_C : 4'h0);
        return sum[15:0];
    endfunction

    function automatic cpu_state_t execute_instr(input instr_t it);
        cpu_state_t r;
        logic [15:0] n16, len;
        logic        t;
        n16 = {it.imm_high, it.imm_low};
        len = 16'd1;
        r = '0;
        r.cycles_taken = 5'd4;
        case (it.opcode)
            OPC_NOP: ;
            OPC_LD_BC: begin bc_reg = n16; len = 16'd3; r.cycles_taken = 5'd12; end
            OPC_ST_BC: begin
                r.write_enable = 1'b1; r.write_address = bc_reg;
                r.write_data = {8'h00, a_reg}; r.cycles_taken = 5'd8;
            end
            OPC_INC_BC: begin bc_reg = bc_reg + 16'd1; r.cycles_taken = 5'd8; end
            OPC_INC_B: bc_reg[15:8] = incr8(bc_reg[15:8]);
            OPC_DEC_B: bc_reg[15:8] = decr8(bc_reg[15:8]);
            OPC_LD_B: begin bc_reg[15:8] = it.imm_low; len = 16'd2; r.cycles_taken = 5'd8; end
            OPC_RLCA: begin t = a_reg[7]; a_reg = {a_reg[6:0], t}; f_reg = {3'b0, t}; end
            OPC_ST_SP: begin
                r.write_enable = 1'b1; r.write_two_bytes = 1'b1; r.write_address = n16;
                r.write_data = sp_model; len = 16'd3; r.cycles_taken = 5'd20;
            end
            OPC_ADD_BC: begin hl_reg = add_to_hl(bc_reg); r.cycles_taken = 5'd8; end
            OPC_LDA_BC, OPC_LDA_DE: begin a_reg = it.mem_data; r.cycles_taken = 5'd8; end
            OPC_DEC_BC: begin bc_reg = bc_reg - 16'd1; r.cycles_taken = 5'd8; end
            OPC_INC_C: bc_reg[7:0] = incr8(bc_reg[7:0]);
            OPC_DEC_C: bc_reg[7:0] = decr8(bc_reg[7:0]);
            OPC_LD_C: begin bc_reg[7:0] = it.imm_low; len = 16'd2; r.cycles_taken = 5'd8; end
            OPC_RRCA: begin t = a_reg[0]; a_reg = {t, a_reg[7:1]}; f_reg = {3'b0, t}; end
            OPC_LD_DE: begin de_reg = n16; len = 16'd3; r.cycles_taken = 5'd12; end
            OPC_ST_DE: begin
                r.write_enable = 1'b1; r.write_address = de_reg;
                r.write_data = {8'h00, a_reg}; r.cycles_taken = 5'd8;
            end
            OPC_INC_DE: begin de_reg = de_reg + 16'd1; r.cycles_taken = 5'd8; end
            OPC_INC_D: de_reg[15:8] = incr8(de_reg[15:8]);
            OPC_DEC_D: de_reg[15:8] = decr8(de_reg[15:8]);
            OPC_LD_D: begin de_reg[15:8] = it.imm_low; len = 16'd2; r.cycles_taken = 5'd8; end
            OPC_RLA: begin
                t = a_reg[7]; a_reg = {a_reg[6:0], f_reg[0]}; f_reg = {3'b0, t};
            end
            OPC_JR: begin
                // The offset is relative to the byte after the operand.
                len = 16'd2 + {{8{it.imm_low[7]}}, it.imm_low};
                r.cycles_taken = 5'd12;
            end
            OPC_ADD_DE: begin hl_reg = add_to_hl(de_reg); r.cycles_taken = 5'd8; end
            OPC_DEC_DE: begin de_reg = de_reg - 16'd1; r.cycles_taken = 5'd8; end
            OPC_INC_E: de_reg[7:0] = incr8(de_reg[7:0]);
            OPC_DEC_E: de_reg[7:0] = decr8(de_reg[7:0]);
            OPC_LD_E: begin de_reg[7:0] = it.imm_low; len = 16'd2; r.cycles_taken = 5'd8; end
            OPC_RRA: begin
                t = a_reg[0]; a_reg = {f_reg[0], a_reg[7:1]}; f_reg = {3'b0, t};
            end
            default: begin r.unsupported = 1'b1; len = 16'd0; r.cycles_taken = 5'd0; end
        endcase
        pc_reg = pc_reg + len;
        r.acc_out = a_reg;
        r.flags_out = {f_reg, 4'h0};
        r.bc_out = bc_reg;
        r.de_out = de_reg;
        r.hl_out = hl_reg;
        r.pc_out = pc_reg;
        return r;
    endfunction

    task automatic push_instr(input logic [7:0] op, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] md);
        instr_t it;
        it.opcode = op; it.imm_low = lo; it.imm_high = hi; it.mem_data = md;
        pending_instrs.push_back(it);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {1'b1, 7'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly valid low-page opcodes, with a share of STOP and high opcodes.
    task automatic push_random(input int count);
        logic [7:0] op;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) op = 8'($urandom);
            else op = 8'($urandom_range(0, 31));
            push_instr(op, pick_byte(), pick_byte(), pick_byte());
        end
    endtask

    task automatic wait_drained();
        while (pending_instrs.size() != 0 || expected_states.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_sp(input logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sp_model = v;
    endtask

    // Driver: bursts and gaps; the model runs on each accepted request.
    // A request still waiting for its handshake is held unchanged.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !in_taken)) begin
            if (hold_sender || pending_instrs.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_instrs[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
        // Receiver stall pattern: long ready runs alternate with choppy stretches.
        stall_phase <= stall_phase + 1;
        if (stall_phase[6]) m_tready <= ($urandom_range(0, 2) != 0);
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        cpu_state_t got, want;
        in_taken = s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_states.push_back(execute_instr(pending_instrs.pop_front()));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (got.unsupported) unsup_seen++;
                if (got.write_enable) writes_seen++;
                if (expected_states.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", m_tdata);
                end else begin
                    want = expected_states.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  exp A=%h F=%h BC=%h DE=%h HL=%h PC=%h cyc=%0d",
                                     want.acc_out, want.flags_out, want.bc_out,
                                     want.de_out, want.hl_out, want.pc_out,
                                     want.cycles_taken);
                            $display("  got A=%h F=%h BC=%h DE=%h HL=%h PC=%h cyc=%0d",
                                     got.acc_out, got.flags_out, got.bc_out,
                                     got.de_out, got.hl_out, got.pc_out,
                                     got.cycles_taken);
                            $display("  exp we=%b two=%b addr=%h data=%h unsup=%b",
                                     want.write_enable, want.write_two_bytes,
                                     want.write_address, want.write_data,
                                     want.unsupported);
                            $display("  got we=%b two=%b addr=%h data=%h unsup=%b",
                                     got.write_enable, got.write_two_bytes,
                                     got.write_address, got.write_data,
                                     got.unsupported);
                        end
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no request or result for %0d cycles", idle_cycles);
                $display("sm83_low_opcode_execute regression: fail");
                $finish;
            end
        end
    end

    initial begin
        cfg_we = 1'b0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        aresetn = 1'b0;
        mismatches = 0; results_seen = 0; idle_cycles = 0;
        gap_left = 0; burst_left = 0; stall_phase = 0;
        hold_sender = 1'b0; in_taken = 1'b0; unsup_seen = 0; writes_seen = 0;
        sp_model = 16'hFFFE;
        a_reg = '0; f_reg = '0; bc_reg = '0; de_reg = '0; hl_reg = '0; pc_reg = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset stack pointer value, wrap of counters, flag corners.
        push_instr(OPC_ST_SP, 8'hFF, 8'hFF, 8'h00);
        push_instr(OPC_DEC_B, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_INC_B, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_DEC_BC, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_INC_BC, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_LD_BC, 8'hFF, 8'hFF, 8'h00);
        push_instr(OPC_LD_DE, 8'h01, 8'h00, 8'h00);
        push_instr(OPC_ADD_DE, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_ADD_BC, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_LDA_BC, 8'h00, 8'h00, 8'h80);
        push_instr(OPC_RLCA, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_RRA, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_RLA, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_RRCA, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_ST_BC, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_LD_E, 8'hFF, 8'h00, 8'h00);
        push_instr(OPC_INC_E, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_LD_D, 8'h0F, 8'h00, 8'h00);
        push_instr(OPC_INC_D, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_LDA_DE, 8'h00, 8'h00, 8'hFF);
        push_instr(OPC_ST_DE, 8'h00, 8'h00, 8'h00);
        push_instr(OPC_JR, 8'h80, 8'h00, 8'h00);
        push_instr(OPC_JR, 8'h7F, 8'h00, 8'h00);
        push_instr(OPC_STOP, 8'hFF, 8'hFF, 8'hFF);
        push_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // Sender holds off until all results are back, then a new stack pointer.
        write_sp(16'h0000);
        push_random(150);
        wait_drained();
        write_sp(16'hFFFF);
        push_random(150);
        wait_drained();
        write_sp(16'($urandom));
        push_instr(OPC_ST_SP, 8'h34, 8'h12, 8'h00);
        push_random(200);
        hold_sender = 1'b1;
        repeat (5) @(posedge aclk);
        hold_sender = 1'b0;
        wait_drained();

        $display("Ran %0d instructions: %0d memory writes, %0d unsupported opcodes,",
                 results_seen, writes_seen, unsup_seen);
        $display("four stack pointer settings and random handshake stalls.");
        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("sm83_low_opcode_execute regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sm83_low_opcode_execute regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sm83_low_opcode_execute.f
+incdir+src
src/sm83_pkg.sv
src/sm83_decode.sv
src/sm83_queue.sv
src/sm83_execute.sv
src/sm83_low_opcode_execute.sv
tb/tb.sv
